FILE: src/calc_pkg.sv
// Shared types, constants and saturation helpers for the calculator ALU.
package calc_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int SERIES_TERMS_DEF = 12;

   localparam int MUL_W  = 48;   // multiplier operand width
   localparam int PROD_W = 96;   // multiplier product width
   localparam int DIV_NW = 72;   // divider dividend / quotient width
   localparam int DIV_DW = 48;   // divider divisor width

   localparam logic [31:0] PI_SCALED = 32'd314159265;
   localparam logic [DIV_DW-1:0] DEG_DIV = 48'd18000000000;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_ABSD = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_POW  = 3'd4,
      OP_TRIG = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_DIV0    = 3'd1,
      ST_ANGLE   = 3'd2,
      ST_INVALID = 3'd3,
      ST_SAT     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RUN,
      S_MULW,
      S_DIVW,
      S_POW,
      S_POW_ACC,
      S_POW_SQ,
      S_TRIG_NUM,
      S_TRIG_RAD,
      S_TRIG_MUL,
      S_TRIG_DIV,
      S_TRIG_END,
      S_TAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] val;
      logic        flag;
   } sat_type;

   // clamp a sign-magnitude value to 32-bit two's complement
   function automatic sat_type sat_sm(input logic neg, input logic [DIV_NW-1:0] mag);
      sat_type r;
      r.flag = 1'b0;
      r.val  = 32'd0;
      if (!neg) begin
         if (mag > DIV_NW'(32'h7FFF_FFFF)) begin
            r.val  = 32'h7FFF_FFFF;
            r.flag = 1'b1;
         end else begin
            r.val = mag[31:0];
         end
      end else begin
         if (mag > DIV_NW'(32'h8000_0000)) begin
            r.val  = 32'h8000_0000;
            r.flag = 1'b1;
         end else begin
            r.val = ~mag[31:0] + 32'd1;
         end
      end
      return r;
   endfunction

   function automatic sat_type sat64(input logic [63:0] v);
      logic        neg;
      logic [63:0] mag;
      neg = v[63];
      mag = neg ? (~v + 64'd1) : v;
      return sat_sm(neg, DIV_NW'(mag));
   endfunction

endpackage

FILE: src/calc_mul.sv
// Shared multiplier: 48x48 unsigned product built from four 32x32 passes.
module calc_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [calc_pkg::MUL_W-1:0]  x,
   input  logic [calc_pkg::MUL_W-1:0]  y,
   output logic                        done,
   output logic [calc_pkg::PROD_W-1:0] prod
);

   logic [calc_pkg::MUL_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [calc_pkg::PROD_W-1:0] acc_ff, acc_in;
   logic [63:0]                 pp_ff, pp_in;
   logic [1:0]                  off_ff, off_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [31:0]                 xs, ys;
   logic [calc_pkg::PROD_W-1:0] pp_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
      pp_ff  <= pp_in;
      off_ff <= off_in;
   end

   always_comb begin
      xs = cnt_ff[1] ? 32'(x_ff[calc_pkg::MUL_W-1:32]) : x_ff[31:0];
      ys = cnt_ff[0] ? 32'(y_ff[calc_pkg::MUL_W-1:32]) : y_ff[31:0];
      case (off_ff)
         2'd0:    pp_shift = {32'd0, pp_ff};
         2'd1:    pp_shift = {pp_ff, 32'd0};
         default: pp_shift = {pp_ff[31:0], 64'd0};
      endcase
   end

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      pp_in   = pp_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            x_in    = x;
            y_in    = y;
            acc_in  = '0;
            cnt_in  = 3'd0;
            busy_in = 1'b1;
         end
      end else begin
         // pass order: lo*lo, lo*hi, hi*lo, hi*hi
         if (cnt_ff != 3'd4) begin
            pp_in  = 64'(xs) * 64'(ys);
            off_in = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
         end
         if (cnt_ff != 3'd0) begin
            acc_in = acc_ff + pp_shift;
         end
         if (cnt_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 3'd1;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

FILE: src/calc_div.sv
// Shared restoring divider: unsigned quotient, one bit per cycle.
module calc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [calc_pkg::DIV_NW-1:0] num,
   input  logic [calc_pkg::DIV_DW-1:0] den,
   output logic                        done,
   output logic [calc_pkg::DIV_NW-1:0] quo
);

   localparam int CNT_W = $clog2(calc_pkg::DIV_NW);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(calc_pkg::DIV_NW - 1);

   logic [calc_pkg::DIV_NW-1:0] quo_ff, quo_in;
   logic [calc_pkg::DIV_DW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [calc_pkg::DIV_DW:0]   trial, diff;
   logic                        ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   always_comb begin
      trial = {rem_ff, quo_ff[calc_pkg::DIV_NW-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            quo_in  = num;
            rem_in  = '0;
            den_in  = den;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else begin
         rem_in = ge ? diff[calc_pkg::DIV_DW-1:0] : trial[calc_pkg::DIV_DW-1:0];
         quo_in = {quo_ff[calc_pkg::DIV_NW-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

FILE: src/calculator_alu_with_sine_cosine_core.sv
// Calculator ALU top level: sequencer around one shared multiplier and one divider.
// One item at a time: an operation code on req_tuser and two signed fixed-point
// operands on req_tdata give one result item of main result, cosine, tangent and
// status. Latency depends on the operation: add and absolute difference finish in
// the sequencer itself, multiply waits on one multiplier run, divide on one divider
// run (the divider retires one quotient bit per cycle over 72 bits), power runs a
// multiply and a square per set exponent bit and a square per clear bit, and trig
// runs a multiplier and a divider pass for each of the 2 * SERIES_TERMS - 1 series
// terms, after the degree-to-radian conversion and before the tangent divide.
// The next item is accepted while a finished result still waits on rsp_tready.
module calculator_alu_with_sine_cosine_core #(
   parameter int FRAC_BITS    = calc_pkg::FRAC_BITS_DEF,
   parameter int SERIES_TERMS = calc_pkg::SERIES_TERMS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  logic [2:0]   req_tuser,   // kind[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // main_result, cosine_value, tangent_value, status, pad
);

   localparam int SH  = 32 - FRAC_BITS;
   localparam int K_W = $clog2(2 * SERIES_TERMS);
   localparam logic [K_W-1:0] K_LAST = K_W'(2 * SERIES_TERMS - 1);
   localparam logic [63:0] ANGLE_MAX = 64'd360 << FRAC_BITS;
   localparam int NW = calc_pkg::DIV_NW;
   localparam int DW = calc_pkg::DIV_DW;
   localparam int MW = calc_pkg::MUL_W;

   calc_pkg::state_type  state_ff, state_in;
   calc_pkg::status_type stat_ff, stat_in, stat_final;

   logic [2:0]   kind_ff, kind_in;
   logic [31:0]  a_ff, a_in, b_ff, b_in;
   logic [31:0]  acc_ff, acc_in, base_ff, base_in, exp_ff, exp_in;
   logic [63:0]  t_mag_ff, t_mag_in, sn_ff, sn_in, cs_ff, cs_in;
   logic         t_neg_ff, t_neg_in, rad_neg_ff, rad_neg_in, sat_ff, sat_in;
   logic [47:0]  rad_ff, rad_in;
   logic [K_W-1:0] k_ff, k_in;
   logic [31:0]  res0_ff, res0_in, res1_ff, res1_in, res2_ff, res2_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [103:0] rsp_data_ff, rsp_data_in;

   logic                         mul_start, mul_done;
   logic [MW-1:0]                mul_x, mul_y;
   logic [calc_pkg::PROD_W-1:0]  mul_prod;
   logic                         div_start, div_done;
   logic [NW-1:0]                div_num, div_quo;
   logic [DW-1:0]                div_den;

   logic         a_neg, b_neg, sn_neg, cs_neg, term_neg, t_neg_next;
   logic [31:0]  a_mag, b_mag, pow_base, pow_exp;
   logic [63:0]  a_ext, b_ext, sum64, absd64, sn_mag, cs_mag, term, acc_shift;
   calc_pkg::sat_type sat_add, sat_absd, sat_mul, sat_div, sat_pow, sat_sin, sat_cos,
                      sat_tan;

   calc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .y     (mul_y),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   calc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      a_neg  = a_ff[31];
      b_neg  = b_ff[31];
      a_mag  = a_neg ? (~a_ff + 32'd1) : a_ff;
      b_mag  = b_neg ? (~b_ff + 32'd1) : b_ff;
      a_ext  = {{32{a_ff[31]}}, a_ff};
      b_ext  = {{32{b_ff[31]}}, b_ff};
      sum64  = a_ext + b_ext;
      absd64 = ($signed(a_ext) > $signed(b_ext)) ? (a_ext - b_ext) : (b_ext - a_ext);
      pow_base = a_neg ? (~(a_mag >> FRAC_BITS) + 32'd1) : (a_mag >> FRAC_BITS);
      // ceiling of a positive exponent, else one
      if (!b_neg && (b_ff != 32'd0)) begin
         pow_exp = (b_ff >> FRAC_BITS) + 32'(b_ff[FRAC_BITS-1:0] != '0);
      end else begin
         pow_exp = 32'd1;
      end
      acc_shift = {{32{acc_ff[31]}}, acc_ff} << FRAC_BITS;
      sn_neg = sn_ff[63];
      cs_neg = cs_ff[63];
      sn_mag = sn_neg ? (~sn_ff + 64'd1) : sn_ff;
      cs_mag = cs_neg ? (~cs_ff + 64'd1) : cs_ff;
      t_neg_next = t_neg_ff ^ rad_neg_ff;
      term_neg   = t_neg_next ^ k_ff[1];
      term       = term_neg ? (~div_quo[63:0] + 64'd1) : div_quo[63:0];
      sat_add  = calc_pkg::sat64(sum64);
      sat_absd = calc_pkg::sat64(absd64);
      sat_mul  = calc_pkg::sat_sm(a_neg ^ b_neg, NW'(mul_prod[63:0] >> FRAC_BITS));
      sat_div  = calc_pkg::sat_sm(a_neg ^ b_neg, div_quo);
      sat_pow  = calc_pkg::sat64(acc_shift);
      sat_sin  = calc_pkg::sat_sm(sn_neg, NW'(sn_mag >> SH));
      sat_cos  = calc_pkg::sat_sm(cs_neg, NW'(cs_mag >> SH));
      sat_tan  = calc_pkg::sat_sm(sn_neg ^ cs_neg, div_quo);
      stat_final = (stat_ff != calc_pkg::ST_OK) ? stat_ff :
                   (sat_ff ? calc_pkg::ST_SAT : calc_pkg::ST_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= calc_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      t_mag_ff    <= t_mag_in;
      t_neg_ff    <= t_neg_in;
      sn_ff       <= sn_in;
      cs_ff       <= cs_in;
      rad_ff      <= rad_in;
      rad_neg_ff  <= rad_neg_in;
      k_ff        <= k_in;
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      res2_ff     <= res2_in;
      stat_ff     <= stat_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      t_mag_in     = t_mag_ff;
      t_neg_in     = t_neg_ff;
      sn_in        = sn_ff;
      cs_in        = cs_ff;
      rad_in       = rad_ff;
      rad_neg_in   = rad_neg_ff;
      k_in         = k_ff;
      res0_in      = res0_ff;
      res1_in      = res1_ff;
      res2_in      = res2_ff;
      stat_in      = stat_ff;
      sat_in       = sat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      mul_start    = 1'b0;
      mul_x        = '0;
      mul_y        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;

      case (state_ff)
         calc_pkg::S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               a_in     = req_tdata[31:0];
               b_in     = req_tdata[63:32];
               res0_in  = '0;
               res1_in  = '0;
               res2_in  = '0;
               stat_in  = calc_pkg::ST_OK;
               sat_in   = 1'b0;
               state_in = calc_pkg::S_RUN;
            end
         end

         calc_pkg::S_RUN: begin
            case (kind_ff)
               calc_pkg::OP_ADD: begin
                  res0_in  = sat_add.val;
                  sat_in   = sat_add.flag;
                  state_in = calc_pkg::S_DONE;
               end
               calc_pkg::OP_ABSD: begin
                  res0_in  = sat_absd.val;
                  sat_in   = sat_absd.flag;
                  state_in = calc_pkg::S_DONE;
               end
               calc_pkg::OP_MUL: begin
                  mul_start = 1'b1;
                  mul_x     = MW'(a_mag);
                  mul_y     = MW'(b_mag);
                  state_in  = calc_pkg::S_MULW;
               end
               calc_pkg::OP_DIV: begin
                  if (b_ff == 32'd0) begin
                     stat_in  = calc_pkg::ST_DIV0;
                     state_in = calc_pkg::S_DONE;
                  end else begin
                     div_start = 1'b1;
                     div_num   = NW'(a_mag) << FRAC_BITS;
                     div_den   = DW'(b_mag);
                     state_in  = calc_pkg::S_DIVW;
                  end
               end
               calc_pkg::OP_POW: begin
                  acc_in   = 32'd1;
                  base_in  = pow_base;
                  exp_in   = pow_exp;
                  state_in = calc_pkg::S_POW;
               end
               calc_pkg::OP_TRIG: begin
                  if (64'(a_mag) > ANGLE_MAX) begin
                     stat_in  = calc_pkg::ST_ANGLE;
                     state_in = calc_pkg::S_DONE;
                  end else begin
                     mul_start  = 1'b1;
                     mul_x      = MW'(a_mag);
                     mul_y      = MW'(calc_pkg::PI_SCALED);
                     t_mag_in   = 64'h1_0000_0000;
                     t_neg_in   = 1'b0;
                     sn_in      = '0;
                     cs_in      = 64'h1_0000_0000;
                     k_in       = K_W'(1);
                     rad_neg_in = a_neg;
                     state_in   = calc_pkg::S_TRIG_NUM;
                  end
               end
               default: begin
                  stat_in  = calc_pkg::ST_INVALID;
                  state_in = calc_pkg::S_DONE;
               end
            endcase
         end

         calc_pkg::S_MULW: begin
            if (mul_done) begin
               res0_in  = sat_mul.val;
               sat_in   = sat_mul.flag;
               state_in = calc_pkg::S_DONE;
            end
         end

         calc_pkg::S_DIVW: begin
            if (div_done) begin
               res0_in  = sat_div.val;
               sat_in   = sat_div.flag;
               state_in = calc_pkg::S_DONE;
            end
         end

         // square and multiply, wrapping at 32 bits
         calc_pkg::S_POW: begin
            if (exp_ff == 32'd0) begin
               res0_in  = sat_pow.val;
               sat_in   = sat_pow.flag;
               state_in = calc_pkg::S_DONE;
            end else if (exp_ff[0]) begin
               mul_start = 1'b1;
               mul_x     = MW'(acc_ff);
               mul_y     = MW'(base_ff);
               state_in  = calc_pkg::S_POW_ACC;
            end else begin
               mul_start = 1'b1;
               mul_x     = MW'(base_ff);
               mul_y     = MW'(base_ff);
               state_in  = calc_pkg::S_POW_SQ;
            end
         end

         calc_pkg::S_POW_ACC: begin
            if (mul_done) begin
               acc_in    = mul_prod[31:0];
               mul_start = 1'b1;
               mul_x     = MW'(base_ff);
               mul_y     = MW'(base_ff);
               state_in  = calc_pkg::S_POW_SQ;
            end
         end

         calc_pkg::S_POW_SQ: begin
            if (mul_done) begin
               base_in  = mul_prod[31:0];
               exp_in   = exp_ff >> 1;
               state_in = calc_pkg::S_POW;
            end
         end

         // degrees to radians with 32 fraction bits
         calc_pkg::S_TRIG_NUM: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = NW'(mul_prod[63:0]) << SH;
               div_den   = calc_pkg::DEG_DIV;
               state_in  = calc_pkg::S_TRIG_RAD;
            end
         end

         calc_pkg::S_TRIG_RAD: begin
            if (div_done) begin
               rad_in    = div_quo[47:0];
               mul_start = 1'b1;
               mul_x     = MW'(t_mag_ff);
               mul_y     = div_quo[47:0];
               state_in  = calc_pkg::S_TRIG_MUL;
            end
         end

         calc_pkg::S_TRIG_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = NW'(mul_prod[calc_pkg::PROD_W-1:32]);
               div_den   = DW'(k_ff);
               state_in  = calc_pkg::S_TRIG_DIV;
            end
         end

         // odd terms feed sine, even terms cosine
         calc_pkg::S_TRIG_DIV: begin
            if (div_done) begin
               t_mag_in = div_quo[63:0];
               t_neg_in = t_neg_next;
               if (k_ff[0]) begin
                  sn_in = sn_ff + term;
               end else begin
                  cs_in = cs_ff + term;
               end
               if (k_ff == K_LAST) begin
                  state_in = calc_pkg::S_TRIG_END;
               end else begin
                  k_in      = k_ff + K_W'(1);
                  mul_start = 1'b1;
                  mul_x     = MW'(div_quo[63:0]);
                  mul_y     = rad_ff;
                  state_in  = calc_pkg::S_TRIG_MUL;
               end
            end
         end

         calc_pkg::S_TRIG_END: begin
            res0_in = sat_sin.val;
            res1_in = sat_cos.val;
            if (cs_ff == 64'd0) begin
               res2_in  = sn_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
               sat_in   = 1'b1;
               state_in = calc_pkg::S_DONE;
            end else begin
               sat_in    = sat_sin.flag | sat_cos.flag;
               div_start = 1'b1;
               div_num   = NW'(sn_mag) << FRAC_BITS;
               div_den   = DW'(cs_mag);
               state_in  = calc_pkg::S_TAN;
            end
         end

         calc_pkg::S_TAN: begin
            if (div_done) begin
               res2_in  = sat_tan.val;
               sat_in   = sat_ff | sat_tan.flag;
               state_in = calc_pkg::S_DONE;
            end
         end

         // hold until the output register is free
         calc_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, stat_final, res2_ff, res1_ff, res0_ff};
               state_in     = calc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = calc_pkg::S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == calc_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: test/calc_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the calculator ALU: predicts each result and compares it.
module calc_result_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,   // operand_a[31:0], operand_b[63:32]
   input  logic [2:0]   req_tuser,   // kind[2:0]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,   // main_result, cosine_value, tangent_value, status, pad
   output int           failures,
   output int           pending
);

   localparam int           FRAC   = calc_pkg::FRAC_BITS_DEF;
   localparam int           TERMS  = calc_pkg::SERIES_TERMS_DEF;
   localparam longint       ONE    = longint'(1) << FRAC;
   localparam longint       PI_NUM = 64'd314159265;
   localparam longint       DEG_D  = 64'd18000000000;

   typedef struct {
      logic [31:0] main_result;
      logic [31:0] cosine_value;
      logic [31:0] tangent_value;
      logic [2:0]  status;
   } calc_answer;

   calc_answer answers_due[$];

   function automatic logic [31:0] clamp32(input longint v, inout bit hit);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         hit = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -longint'(64'h8000_0000)) begin
         hit = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic longint trunc_shift(input longint v, input int sh);
      longint m;
      m = (v < 0 ? -v : v) >>> sh;
      return v < 0 ? -m : m;
   endfunction

   // (x*y) >> 32 on magnitudes, sign applied after
   function automatic longint mul_q32(input longint x, input longint y);
      logic [127:0] p;
      longint       r;
      p = 128'(x < 0 ? -x : x) * 128'(y < 0 ? -y : y);
      r = longint'(p[95:32]);
      return ((x < 0) != (y < 0)) ? -r : r;
   endfunction

   function automatic calc_answer compute_answer(input logic [2:0] kind,
                                                 input logic [31:0] ra,
                                                 input logic [31:0] rb);
      calc_answer   ans;
      bit           hit;
      longint       a, b, n, q, rad, t, sn, cs, trm;
      longint unsigned am, num, rm;
      logic [31:0]  base, acc;
      ans = '{default: '0};
      hit = 1'b0;
      a = longint'(signed'(ra));
      b = longint'(signed'(rb));
      case (kind)
         calc_pkg::OP_ADD:  ans.main_result = clamp32(a + b, hit);
         calc_pkg::OP_ABSD: ans.main_result = clamp32(a > b ? a - b : b - a, hit);
         calc_pkg::OP_MUL:  ans.main_result = clamp32(trunc_shift(a * b, FRAC), hit);
         calc_pkg::OP_DIV: begin
            if (b == 0) ans.status = calc_pkg::ST_DIV0;
            else ans.main_result = clamp32((a * ONE) / b, hit);
         end
         calc_pkg::OP_POW: begin
            q = a / ONE;
            base = q[31:0];
            n = b / ONE;
            if (b % ONE != 0 && b > 0) n++;
            if (n < 1) n = 1;
            acc = 32'd1;
            while (n != 0) begin
               if (n[0]) acc = acc * base;
               base = base * base;
               n = n >> 1;
            end
            ans.main_result = clamp32(longint'(signed'(acc)) * ONE, hit);
         end
         calc_pkg::OP_TRIG: begin
            am = a < 0 ? -a : a;
            if (am > (longint'(360) << FRAC)) begin
               ans.status = calc_pkg::ST_ANGLE;
            end else begin
               num = am * PI_NUM;
               rm = ((num / DEG_D) << (32 - FRAC)) +
                    (((num % DEG_D) << (32 - FRAC)) / DEG_D);
               rad = a < 0 ? -longint'(rm) : longint'(rm);
               t = longint'(1) << 32;
               sn = 0;
               cs = t;
               for (int k = 1; k <= 2 * TERMS - 1; k++) begin
                  t = mul_q32(t, rad) / k;
                  trm = k[1] ? -t : t;
                  if (k[0]) sn += trm;
                  else cs += trm;
               end
               ans.main_result  = clamp32(trunc_shift(sn, 32 - FRAC), hit);
               ans.cosine_value = clamp32(trunc_shift(cs, 32 - FRAC), hit);
               if (cs == 0) begin
                  hit = 1'b1;
                  ans.tangent_value = sn < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  ans.tangent_value = clamp32((sn * ONE) / cs, hit);
               end
            end
         end
         default: ans.status = calc_pkg::ST_INVALID;
      endcase
      if (ans.status == calc_pkg::ST_OK && hit) ans.status = calc_pkg::ST_SAT;
      return ans;
   endfunction

   assign pending = answers_due.size();

   always @(posedge clock) begin
      calc_answer want;
      if (reset) begin
         failures <= 0;
      end else begin
         if (req_tvalid && req_tready)
            answers_due.push_back(compute_answer(req_tuser, req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $error("result item with nothing expected: %h", rsp_tdata);
               failures <= failures + 1;
            end else begin
               want = answers_due.pop_front();
               if (rsp_tdata[31:0] !== want.main_result ||
                   rsp_tdata[63:32] !== want.cosine_value ||
                   rsp_tdata[95:64] !== want.tangent_value ||
                   rsp_tdata[98:96] !== want.status)
                  failures <= failures + 1;
               if (rsp_tdata[31:0] !== want.main_result)
                  $error("main_result expected %h got %h", want.main_result, rsp_tdata[31:0]);
               if (rsp_tdata[63:32] !== want.cosine_value)
                  $error("cosine_value expected %h got %h", want.cosine_value, rsp_tdata[63:32]);
               if (rsp_tdata[95:64] !== want.tangent_value)
                  $error("tangent_value expected %h got %h", want.tangent_value,
                         rsp_tdata[95:64]);
               if (rsp_tdata[98:96] !== want.status)
                  $error("status expected %0d got %0d", want.status, rsp_tdata[98:96]);
            end
         end
      end
   end

endmodule

FILE: test/tb_calculator_alu_with_sine_cosine_core.sv
`timescale 1ns / 100ps
// Testbench top for the calculator ALU: clock, reset, stimulus and verdict.
module tb_calculator_alu_with_sine_cosine_core;

   localparam logic [2:0] KIND_BAD_LO = 3'd6;
   localparam logic [2:0] KIND_BAD_HI = 3'd7;
   localparam int         CYCLE_LIMIT = 10_000_000;
   localparam int         DEG_ONE     = 65536;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   int           failures, pending;
   int           send_idle = 0, stall_pct = 0;
   bit           hold_rsp = 1'b0, start_hold = 1'b0;
   int           cycles = 0;

   always #5 clock = ~clock;

   calculator_alu_with_sine_cosine_core DUT (.*);
   calc_result_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("calculator_alu_with_sine_cosine_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= !reset && !hold_rsp && ($urandom_range(99) >= stall_pct);

   // long receiver hold-off, counted on its own
   initial begin
      wait (start_hold);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (3000) @(negedge clock);
      hold_rsp = 1'b0;
   end

   task automatic send_item(input logic [2:0] kind, input logic [31:0] a, input logic [31:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random();
      logic [2:0]  kind;
      logic [31:0] a, b;
      int          pick;
      pick = $urandom_range(99);
      kind = pick < 4 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      a = $urandom_range(3) == 0 ? $urandom :
          32'($signed($urandom_range(20 * DEG_ONE)) - 10 * DEG_ONE);
      b = $urandom_range(3) == 0 ? $urandom :
          32'($signed($urandom_range(20 * DEG_ONE)) - 10 * DEG_ONE);
      if (kind == calc_pkg::OP_TRIG && $urandom_range(9) != 0)
         a = 32'($signed($urandom_range(720 * DEG_ONE)) - 360 * DEG_ONE);
      if (kind == calc_pkg::OP_POW && $urandom_range(3) != 0)
         b = 32'($urandom_range(12 * DEG_ONE));
      if (kind == calc_pkg::OP_DIV && $urandom_range(15) == 0)
         b = '0;
      send_item(kind, a, b);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(calc_pkg::OP_ADD,  32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(calc_pkg::OP_ADD,  32'h8000_0000, 32'h8000_0000);
      send_item(calc_pkg::OP_ADD,  32'h0001_8000, 32'hFFFF_0000);
      send_item(calc_pkg::OP_ABSD, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(calc_pkg::OP_ABSD, 32'hFFFE_0000, 32'h0003_0000);
      send_item(calc_pkg::OP_MUL,  32'h8000_0000, 32'h8000_0000);
      send_item(calc_pkg::OP_MUL,  32'hFFFE_8000, 32'h0001_4000);
      send_item(calc_pkg::OP_DIV,  32'h0005_0000, 32'h0000_0000);
      send_item(calc_pkg::OP_DIV,  32'hFFF9_0000, 32'h0002_0000);
      send_item(calc_pkg::OP_DIV,  32'h7FFF_FFFF, 32'h0000_0001);
      send_item(calc_pkg::OP_POW,  32'hFFFD_8000, 32'h0002_4000);
      send_item(calc_pkg::OP_POW,  32'h0007_0000, 32'h8000_0000);
      send_item(calc_pkg::OP_POW,  32'h0003_0000, 32'h7FFF_FFFF);
      send_item(calc_pkg::OP_TRIG, 32'h0000_0000, 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(90 * DEG_ONE), 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(-270 * DEG_ONE), 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(360 * DEG_ONE), 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(-360 * DEG_ONE), 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(360 * DEG_ONE + 1), 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'h8000_0000, 32'h0);
      send_item(calc_pkg::OP_TRIG, 32'(-30 * DEG_ONE), 32'h0);
      send_item(KIND_BAD_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(KIND_BAD_HI, 32'h1234_5678, 32'h8765_4321);
      // pause until every result is back
      drain();

      start_hold <= 1'b1;
      repeat (190) send_random();
      send_idle <= 64;
      repeat (190) send_random();
      send_idle <= 0;
      stall_pct <= 64;
      repeat (190) send_random();
      send_idle <= 13;
      stall_pct <= 13;
      repeat (190) send_random();
      drain();
      repeat (200) @(posedge clock);

      if (failures == 0)
         $display("calculator_alu_with_sine_cosine_core: match");
      else
         $display("calculator_alu_with_sine_cosine_core: mismatch");
      $finish;
   end

endmodule
